// ----- rtl/mrps_pkg.sv -----
package mrps_pkg;

   localparam int NUM_REGS_DEF = 16;

   // Function codes
   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

   // Exception flag and codes
   localparam logic [7:0] EXC_FLAG         = 8'h80;
   localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
   localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;

   // Holding store reset base, plus the register index
   localparam logic [15:0] HOLD_BASE = 16'h1000;

   // Request header fields as captured, plus the position of the last byte
   typedef struct packed {
      logic [7:0]  func_code;
      logic [15:0] start_address;
      logic [15:0] count_or_value;
      logic [7:0]  byte_count_field;
      logic [7:0]  last_pos;
   } pdu_fields_type;

endpackage

// ----- rtl/mrps_alu.sv -----
module mrps_alu
   import mrps_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  logic [16:0] op_a,
   input  logic [16:0] op_b,
   output logic [16:0] sum,
   output logic        over
);

   // Shared adder and limit compare: range checks and register indexing
   assign sum  = op_a + op_b;
   assign over = sum > 17'(NUM_REGS);

endmodule

// ----- rtl/mrps_store.sv -----
module mrps_store
   import mrps_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF,
   parameter int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [15:0]       wr_data,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [15:0]       rd_data
);

   logic [15:0] regs_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= HOLD_BASE + 16'(i);
         end
      end else if (wr_en) begin
         regs_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = regs_ff[rd_idx];

endmodule

// ----- rtl/mrps_ctrl.sv -----
module mrps_ctrl
   import mrps_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF,
   parameter int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1,
   parameter int CNT_W    = $clog2(NUM_REGS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pdu_fields_type    fields,
   output logic              req_ready,
   output logic              store_wr_en,
   output logic [15:0]       store_wr_data,
   output logic [IDX_W-1:0]  store_idx,
   input  logic [15:0]       store_rd_data,
   output logic              stage_rd_en,
   output logic [IDX_W-1:0]  stage_rd_idx,
   input  logic [15:0]       stage_rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last
);

   typedef enum logic [3:0] {
      ST_RX,
      ST_CHECK,
      ST_EXC,
      ST_RD_HDR,
      ST_RD_DATA,
      ST_COMMIT_RD,
      ST_COMMIT_WR,
      ST_SINGLE_WR,
      ST_ECHO
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [2:0]       seq_ff, seq_in;
   logic [7:0]       exc_ff, exc_in;
   logic [15:0]      word_ff, word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic        slot_free;
   logic        emit;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic        k_last;
   logic        bad_multi;
   logic [16:0] alu_b;
   logic [16:0] alu_sum;
   logic        alu_over;

   mrps_alu #(.NUM_REGS(NUM_REGS)) u_alu (
      .op_a (17'(fields.start_address)),
      .op_b (alu_b),
      .sum  (alu_sum),
      .over (alu_over)
   );

   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign k_last       = (16'(k_ff) + 16'd1) == fields.count_or_value;
   assign store_idx    = alu_sum[IDX_W-1:0];
   assign stage_rd_idx = k_ff[IDX_W-1:0];
   assign req_ready    = state_ff == ST_RX;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte     = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   assign bad_multi = (fields.count_or_value == 16'd0) || alu_over ||
                      (fields.last_pos < 8'd5) ||
                      (17'(fields.byte_count_field) != {fields.count_or_value, 1'b0}) ||
                      (9'(fields.last_pos) < 9'(fields.byte_count_field) + 9'd5);

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      seq_in        = seq_ff;
      exc_in        = exc_ff;
      word_in       = word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      emit          = 1'b0;
      emit_byte     = 8'h00;
      emit_last     = 1'b0;
      store_wr_en   = 1'b0;
      store_wr_data = fields.count_or_value;
      stage_rd_en   = 1'b0;
      alu_b         = 17'(k_ff);

      case (state_ff)
         ST_RX: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            alu_b  = (fields.func_code == FC_WRITE_SINGLE) ? 17'd1
                                                           : 17'(fields.count_or_value);
            k_in   = '0;
            seq_in = '0;
            if (fields.last_pos < 8'd4) begin
               exc_in   = EXC_ILLEGAL_FUNC;
               state_in = ST_EXC;
            end else begin
               case (fields.func_code)
                  FC_READ_HOLDING: begin
                     if (fields.count_or_value == 16'd0 || alu_over) begin
                        exc_in   = EXC_ILLEGAL_ADDR;
                        state_in = ST_EXC;
                     end else begin
                        state_in = ST_RD_HDR;
                     end
                  end
                  FC_WRITE_SINGLE: begin
                     if (alu_over) begin
                        exc_in   = EXC_ILLEGAL_ADDR;
                        state_in = ST_EXC;
                     end else begin
                        state_in = ST_SINGLE_WR;
                     end
                  end
                  FC_WRITE_MULTI: begin
                     if (bad_multi) begin
                        exc_in   = EXC_ILLEGAL_ADDR;
                        state_in = ST_EXC;
                     end else begin
                        state_in = ST_COMMIT_RD;
                     end
                  end
                  default: begin
                     exc_in   = EXC_ILLEGAL_FUNC;
                     state_in = ST_EXC;
                  end
               endcase
            end
         end
         ST_EXC: begin
            if (slot_free) begin
               emit = 1'b1;
               if (seq_ff == 3'd0) begin
                  emit_byte = fields.func_code | EXC_FLAG;
                  seq_in    = 3'd1;
               end else begin
                  emit_byte = exc_ff;
                  emit_last = 1'b1;
                  state_in  = ST_RX;
               end
            end
         end
         ST_RD_HDR: begin
            if (slot_free) begin
               emit = 1'b1;
               if (seq_ff == 3'd0) begin
                  emit_byte = FC_READ_HOLDING;
                  seq_in    = 3'd1;
               end else begin
                  emit_byte = {fields.count_or_value[6:0], 1'b0};
                  seq_in    = 3'd0;
                  state_in  = ST_RD_DATA;
               end
            end
         end
         ST_RD_DATA: begin
            if (slot_free) begin
               emit = 1'b1;
               if (seq_ff == 3'd0) begin
                  word_in   = store_rd_data;
                  emit_byte = store_rd_data[15:8];
                  seq_in    = 3'd1;
               end else begin
                  emit_byte = word_ff[7:0];
                  seq_in    = 3'd0;
                  if (k_last) begin
                     emit_last = 1'b1;
                     state_in  = ST_RX;
                  end else begin
                     k_in = k_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_COMMIT_RD: begin
            stage_rd_en = 1'b1;
            state_in    = ST_COMMIT_WR;
         end
         ST_COMMIT_WR: begin
            store_wr_en   = 1'b1;
            store_wr_data = stage_rd_data;
            if (k_last) begin
               k_in     = '0;
               seq_in   = '0;
               state_in = ST_ECHO;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_COMMIT_RD;
            end
         end
         ST_SINGLE_WR: begin
            store_wr_en = 1'b1;
            seq_in      = '0;
            state_in    = ST_ECHO;
         end
         ST_ECHO: begin
            if (slot_free) begin
               emit = 1'b1;
               case (seq_ff)
                  3'd0:    emit_byte = fields.func_code;
                  3'd1:    emit_byte = fields.start_address[15:8];
                  3'd2:    emit_byte = fields.start_address[7:0];
                  3'd3:    emit_byte = fields.count_or_value[15:8];
                  default: emit_byte = fields.count_or_value[7:0];
               endcase
               if (seq_ff == 3'd4) begin
                  emit_last = 1'b1;
                  state_in  = ST_RX;
               end else begin
                  seq_in = seq_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_RX;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RX;
         k_ff         <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exc_ff      <= exc_in;
      word_ff     <= word_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_no_write_while_rx: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !store_wr_en)
      else $error("holding store written while taking request words");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> !alu_over && (alu_sum < 17'(NUM_REGS)))
      else $error("holding store write index out of range");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_DATA) |-> (alu_sum < 17'(NUM_REGS)))
      else $error("holding store read index out of range");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      32'(k_ff) < NUM_REGS)
      else $error("word counter beyond register count");

   a_last_returns_rx: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> req_ready)
      else $error("final response word not followed by request side opening");

endmodule

// ----- rtl/modbus_register_pdu_server_top.sv -----
// Channel   | Direction | Ports                                   | Word
// ----------+-----------+-----------------------------------------+---------------------------
// request   | in        | req_valid, req_ready, req_pdu_byte,     | one request PDU byte
//           |           | req_last_byte                           | (last mark on final byte)
// response  | out       | rsp_valid, rsp_ready, rsp_resp_byte,    | one response PDU byte
//           |           | rsp_resp_last                           | (last mark on final byte)
//
// Sequence: request words are taken while req_ready is high. After the last word the
//   sequencer runs the range checks in the shared adder/compare unit, then loads one
//   response word per cycle into the output register unless rsp_ready stalls it. A write
//   commit (staging read and store write per register, or one store write) precedes the echo.
// req_ready is low from the last request word until the final response word is loaded.
// Reset clears control state and reloads the holding store with 0x1000 plus its index in
//   the same cycle; no clearing pass follows.
// A stalled response (rsp_ready low) holds the output register and the next response word.
module modbus_register_pdu_server_top
   import mrps_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pdu_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_resp_byte,
   output logic       rsp_resp_last
);

   localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CNT_W = $clog2(NUM_REGS + 1);

   // Request capture: position counter and header fields
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  func_code_ff, func_code_in;
   logic [15:0] start_address_ff, start_address_in;
   logic [15:0] count_or_value_ff, count_or_value_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  last_pos_ff, last_pos_in;

   logic           accept;
   logic           start;
   logic [7:0]     data_off;
   logic [6:0]     stage_word;
   logic           stage_wr;
   pdu_fields_type fields;

   // Staging memory, one array per byte lane so each request word writes one lane
   logic [7:0]  stage_hi_mem [NUM_REGS];
   logic [7:0]  stage_lo_mem [NUM_REGS];
   logic [15:0] stage_rd_data_ff;

   logic              stage_rd_en;
   logic [IDX_W-1:0]  stage_rd_idx;
   logic              store_wr_en;
   logic [15:0]       store_wr_data;
   logic [IDX_W-1:0]  store_idx;
   logic [15:0]       store_rd_data;

   assign accept = req_valid && req_ready;
   assign start  = accept && req_last_byte;

   // Data words start at byte six; two bytes per staged word, high byte first
   assign data_off   = byte_index_ff - 8'd6;
   assign stage_word = data_off[7:1];
   assign stage_wr   = accept && (byte_index_ff >= 8'd6) && (stage_word < 7'(NUM_REGS));

   always_comb begin
      byte_index_in     = byte_index_ff;
      func_code_in      = func_code_ff;
      start_address_in  = start_address_ff;
      count_or_value_in = count_or_value_ff;
      byte_count_in     = byte_count_ff;
      last_pos_in       = last_pos_ff;
      if (accept) begin
         case (byte_index_ff)
            8'd0:    func_code_in             = req_pdu_byte;
            8'd1:    start_address_in[15:8]   = req_pdu_byte;
            8'd2:    start_address_in[7:0]    = req_pdu_byte;
            8'd3:    count_or_value_in[15:8]  = req_pdu_byte;
            8'd4:    count_or_value_in[7:0]   = req_pdu_byte;
            8'd5:    byte_count_in            = req_pdu_byte;
            default: ;
         endcase
         if (req_last_byte) begin
            // remember where the request ended, rewind for the next PDU
            last_pos_in   = byte_index_ff;
            byte_index_in = 8'd0;
         end else if (byte_index_ff != 8'd255) begin
            // advance, saturating on very long requests
            byte_index_in = byte_index_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff     <= 8'd0;
         func_code_ff      <= 8'd0;
         start_address_ff  <= 16'd0;
         count_or_value_ff <= 16'd0;
         byte_count_ff     <= 8'd0;
         last_pos_ff       <= 8'd0;
      end else begin
         byte_index_ff     <= byte_index_in;
         func_code_ff      <= func_code_in;
         start_address_ff  <= start_address_in;
         count_or_value_ff <= count_or_value_in;
         byte_count_ff     <= byte_count_in;
         last_pos_ff       <= last_pos_in;
      end
   end

   // Staging write from the request side, registered read for the commit sweep
   always_ff @(posedge clock) begin
      if (stage_wr) begin
         if (data_off[0] == 1'b0) begin
            stage_hi_mem[stage_word[IDX_W-1:0]] <= req_pdu_byte;
         end else begin
            stage_lo_mem[stage_word[IDX_W-1:0]] <= req_pdu_byte;
         end
      end
      if (stage_rd_en) begin
         stage_rd_data_ff <= {stage_hi_mem[stage_rd_idx], stage_lo_mem[stage_rd_idx]};
      end
   end

   assign fields.func_code        = func_code_ff;
   assign fields.start_address    = start_address_ff;
   assign fields.count_or_value   = count_or_value_ff;
   assign fields.byte_count_field = byte_count_ff;
   assign fields.last_pos         = last_pos_ff;

   mrps_store #(
      .NUM_REGS (NUM_REGS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_wr_en),
      .wr_idx  (store_idx),
      .wr_data (store_wr_data),
      .rd_idx  (store_idx),
      .rd_data (store_rd_data)
   );

   mrps_ctrl #(
      .NUM_REGS (NUM_REGS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .fields        (fields),
      .req_ready     (req_ready),
      .store_wr_en   (store_wr_en),
      .store_wr_data (store_wr_data),
      .store_idx     (store_idx),
      .store_rd_data (store_rd_data),
      .stage_rd_en   (stage_rd_en),
      .stage_rd_idx  (stage_rd_idx),
      .stage_rd_data (stage_rd_data_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_byte      (rsp_resp_byte),
      .rsp_last      (rsp_resp_last)
   );

endmodule
